FILE: rtl/core/aes_pkg.sv
// Package with AES constants, types and round functions.
package aes_pkg;

    localparam int NUM_ROUNDS_DEF = 10;
    localparam int BLOCK_W        = 128;
    localparam int KEY_IDX_W      = 4;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_ENCRYPT = 1'b1;

    typedef logic [BLOCK_W-1:0] t_block;

    // Key write sent to every cell of the row of rounds.
    typedef struct packed {
        logic                 valid;
        logic [KEY_IDX_W-1:0] idx;
        t_block               key;
    } t_key_wr;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
        8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
        8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
        8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
        8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
        8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
        8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
        8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
        8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
        8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
        8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
        8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
        8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
        8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
        8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
        8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    endfunction

    // Byte i of the state sits in bits 127-8i down to 120-8i.
    function automatic logic [7:0] get_byte(input t_block s, input int i);
        return s[BLOCK_W-1-8*i -: 8];
    endfunction

    function automatic t_block sub_shift(input t_block s);
        t_block t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[BLOCK_W-1-8*(4*c+r) -: 8] = SBOX[get_byte(s, 4*((c+r)%4)+r)];
            end
        end
        return t;
    endfunction

    function automatic t_block mix_columns(input t_block s);
        t_block t;
        logic [7:0] a0, a1, a2, a3, all;
        for (int c = 0; c < 4; c++) begin
            a0  = get_byte(s, 4*c);
            a1  = get_byte(s, 4*c+1);
            a2  = get_byte(s, 4*c+2);
            a3  = get_byte(s, 4*c+3);
            all = a0 ^ a1 ^ a2 ^ a3;
            t[BLOCK_W-1-8*(4*c)   -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
            t[BLOCK_W-1-8*(4*c+1) -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
            t[BLOCK_W-1-8*(4*c+2) -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
            t[BLOCK_W-1-8*(4*c+3) -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
        end
        return t;
    endfunction

endpackage

FILE: rtl/core/aes_round_cell.sv
// One round cell: holds its round key and applies one cipher round per cycle while i_en is high.
module aes_round_cell #(
    parameter int                           ROUND_IDX  = 1,
    parameter bit                           LAST_ROUND = 1'b0
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  aes_pkg::t_key_wr                i_key_wr,
    input  logic                            i_valid,
    input  aes_pkg::t_block                 i_state,
    output logic                            o_valid,
    output aes_pkg::t_block                 o_state
);

    aes_pkg::t_block r_key;
    aes_pkg::t_block r_state;
    logic            r_valid;
    aes_pkg::t_block n_state;

    always_comb begin
        n_state = aes_pkg::sub_shift(i_state);
        if (!LAST_ROUND) begin
            n_state = aes_pkg::mix_columns(n_state);
        end
        n_state = n_state ^ r_key;
    end

    always_ff @(posedge i_clk) begin
        if (i_key_wr.valid &&
            i_key_wr.idx == ROUND_IDX[aes_pkg::KEY_IDX_W-1:0]) begin
            r_key <= i_key_wr.key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_state <= n_state;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;

endmodule

FILE: rtl/core/aes128_block_encrypt.sv
// Top level of the pipelined AES block encryptor.
// This block encrypts one 128-bit block per cycle while the sink keeps up, with
// AES using round keys that the user loads beforehand; it does no key expansion.
// A transaction with operation 0 writes data into round key slot key_round (slots
// 0 to NUM_ROUNDS; a higher index is ignored) and produces no output. A transaction
// with operation 1 encrypts the data and produces one output transaction. The block
// passes NUM_ROUNDS + 1 register stages, the first of which is loaded at the
// accepting edge; a new block can be accepted while earlier ones are in flight. The
// pipeline is a row of one input stage (key 0 add) and NUM_ROUNDS round cells,
// each holding its own round key and passing its state to the next cell every
// cycle that the row advances. The whole row advances whenever the last stage is
// empty or its result is taken, so the throughput is one block per cycle while the
// sink keeps up.
// Keys may only be reloaded while no encryption is in flight; a slot must be
// loaded before any block uses it.
module aes128_block_encrypt #(
    parameter int NUM_ROUNDS = aes_pkg::NUM_ROUNDS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: key_round [3:0], data_hi [67:4], data_lo [131:68], zeros [135:132]
    input  logic [135:0] s_axis_tdata,
    // tuser: operation
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: cipher_hi [63:0], cipher_lo [127:64]
    output logic [127:0] m_axis_tdata
);

    localparam int NCELL = NUM_ROUNDS + 1;

    logic                 adv;
    logic                 acc;
    aes_pkg::t_key_wr     key_wr;
    aes_pkg::t_block      in_blk;
    aes_pkg::t_block      r_key0;
    aes_pkg::t_block      r_s0;
    logic                 r_v0;
    logic                 vld   [NCELL];
    aes_pkg::t_block      st    [NCELL];

    assign adv           = !vld[NCELL-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign in_blk        = {s_axis_tdata[67:4], s_axis_tdata[131:68]};

    always_comb begin
        key_wr.valid = acc && (s_axis_tuser == aes_pkg::OP_LOAD) &&
                       ({1'b0, s_axis_tdata[3:0]} <= 5'(NUM_ROUNDS));
        key_wr.idx   = s_axis_tdata[3:0];
        key_wr.key   = in_blk;
    end

    always_ff @(posedge i_clk) begin
        if (key_wr.valid && key_wr.idx == '0) begin
            r_key0 <= key_wr.key;
        end
    end

    // Input stage: key 0 add.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (adv) begin
            r_v0 <= acc && (s_axis_tuser == aes_pkg::OP_ENCRYPT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s0 <= in_blk ^ r_key0;
        end
    end

    assign vld[0] = r_v0;
    assign st[0]  = r_s0;

    for (genvar g = 1; g < NCELL; g++) begin : g_round
        aes_round_cell #(
            .ROUND_IDX  (g),
            .LAST_ROUND (g == NUM_ROUNDS)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (adv),
            .i_key_wr (key_wr),
            .i_valid  (vld[g-1]),
            .i_state  (st[g-1]),
            .o_valid  (vld[g]),
            .o_state  (st[g])
        );
    end

    assign m_axis_tvalid = vld[NCELL-1];
    assign m_axis_tdata  = {st[NCELL-1][63:0], st[NCELL-1][127:64]};

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed while stalled");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");
    a_load_nores: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && s_axis_tuser == aes_pkg::OP_LOAD |=> !r_v0)
        else $error("load produced a block in flight");
`endif

endmodule
